// ===== rtl/core/bqdf2_pkg.sv =====
// Shared types and constants for the multichannel direct form II biquad.
// Used by the controller, the datapath and the top level; no dependencies.
package bqdf2_pkg;

  // Channel count and index widths
  localparam int CHANNELS   = 8;
  localparam int CH_W       = 3;
  localparam int CH_CMP_W   = 7;
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths
  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 26;
  localparam int STATE_W    = 32;
  localparam int PROD_W     = COEF_W + STATE_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int FRAC_SHIFT = 22;
  localparam int CFG_IDX_W  = 3;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  // Coefficient register indexes
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  localparam logic [COEF_W-1:0] B0_RESET = 26'd4194304;

  // Multiplier operand pairs
  localparam logic [2:0] MUL_A1_D1 = 3'd0;
  localparam logic [2:0] MUL_A2_D2 = 3'd1;
  localparam logic [2:0] MUL_B1_D1 = 3'd2;
  localparam logic [2:0] MUL_B2_D2 = 3'd3;
  localparam logic [2:0] MUL_B0_W  = 3'd4;

  // Accumulator operations
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_INIT = 2'd1;
  localparam logic [1:0] ACC_STEP = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load;
    logic [2:0] mul_op;
    logic [1:0] accw_op;
    logic [1:0] accy_op;
    logic       w_load;
    logic       finish;
  } bqdf2_cmd_t;

endpackage

// ===== rtl/core/bqdf2_ctrl.sv =====
// Sequencer for one biquad item: load, five shared multiplies, result hand-off.
// Depends on bqdf2_pkg for the command struct and operation codes.
module bqdf2_ctrl
  import bqdf2_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic       out_tready,
  output logic       out_tvalid,
  output bqdf2_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_M0   = 3'd1;
  localparam logic [2:0] S_M1   = 3'd2;
  localparam logic [2:0] S_M2   = 3'd3;
  localparam logic [2:0] S_M3   = 3'd4;
  localparam logic [2:0] S_M4   = 3'd5;
  localparam logic [2:0] S_M5   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Decode state into datapath commands and next state
  always_comb begin
    cmd           = '0;
    cmd.mul_op    = MUL_A1_D1;
    cmd.accw_op   = ACC_HOLD;
    cmd.accy_op   = ACC_HOLD;
    state_nxt     = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_M0;
        end
      end
      S_M0: begin
        cmd.mul_op = MUL_A1_D1;
        state_nxt  = S_M1;
      end
      S_M1: begin
        cmd.mul_op  = MUL_A2_D2;
        cmd.accw_op = ACC_INIT;
        state_nxt   = S_M2;
      end
      S_M2: begin
        cmd.mul_op  = MUL_B1_D1;
        cmd.accw_op = ACC_STEP;
        state_nxt   = S_M3;
      end
      S_M3: begin
        cmd.mul_op  = MUL_B2_D2;
        cmd.w_load  = 1'b1;
        cmd.accy_op = ACC_INIT;
        state_nxt   = S_M4;
      end
      S_M4: begin
        cmd.mul_op  = MUL_B0_W;
        cmd.accy_op = ACC_STEP;
        state_nxt   = S_M5;
      end
      S_M5: begin
        cmd.accy_op = ACC_STEP;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid: set on finish, drop when the transaction completes
  always_comb begin
    priority if (cmd.finish) out_valid_nxt = 1'b1;
    else if (out_tready)     out_valid_nxt = 1'b0;
    else                     out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/bqdf2_dp.sv =====
// Datapath: coefficient registers, per-channel delay lines, one shared
// 26x32 multiplier and two accumulators. Depends on bqdf2_pkg.
module bqdf2_dp
  import bqdf2_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COEF_W-1:0]          cfg_wdata,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic [CH_W-1:0]            channel_index,
  input  bqdf2_cmd_t                 cmd,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic [CH_W-1:0]            channel_out
);

  localparam logic [CH_CMP_W-1:0] CH_LIMIT = CH_CMP_W'(CHANNELS);

  logic signed [COEF_W-1:0]  b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [STATE_W-1:0] d1_arr_r [CHANNELS];
  logic signed [STATE_W-1:0] d2_arr_r [CHANNELS];

  logic signed [SAMPLE_W-1:0] x_r;
  logic [CH_W-1:0]            ch_r;
  logic [CH_IDX_W-1:0]        idx_r;
  logic                       in_range_r;
  logic signed [STATE_W-1:0]  d1_r, d2_r, w_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    accw_r, accy_r;
  logic signed [SAMPLE_W-1:0] sample_out_r;
  logic [CH_W-1:0]            channel_out_r;

  logic [CH_CMP_W-1:0]        ch_ext;
  logic                       in_range;
  logic [CH_IDX_W-1:0]        idx;
  logic signed [COEF_W-1:0]   coef_sel;
  logic signed [STATE_W-1:0]  val_sel;
  logic signed [ACC_W-1:0]    prod_ext, x_sh;
  logic signed [STATE_W-1:0]  w_sat;
  logic signed [SAMPLE_W-1:0] y_sat;

  // Channel range check and delay line index
  assign ch_ext   = {{(CH_CMP_W-CH_W){1'b0}}, channel_index};
  assign in_range = (ch_ext < CH_LIMIT);
  assign idx      = ch_ext[CH_IDX_W-1:0];

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= B0_RESET;
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_B0:  b0_r <= cfg_wdata;
        REG_B1:  b1_r <= cfg_wdata;
        REG_B2:  b2_r <= cfg_wdata;
        REG_A1:  a1_r <= cfg_wdata;
        REG_A2:  a2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture the item and its channel's delay values
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r        <= sample_in;
      ch_r       <= channel_index;
      idx_r      <= idx;
      in_range_r <= in_range;
      d1_r       <= in_range ? d1_arr_r[idx] : '0;
      d2_r       <= in_range ? d2_arr_r[idx] : '0;
    end
  end

  // Multiplier operand select
  always_comb begin
    unique case (cmd.mul_op)
      MUL_A1_D1: begin coef_sel = a1_r; val_sel = d1_r; end
      MUL_A2_D2: begin coef_sel = a2_r; val_sel = d2_r; end
      MUL_B1_D1: begin coef_sel = b1_r; val_sel = d1_r; end
      MUL_B2_D2: begin coef_sel = b2_r; val_sel = d2_r; end
      MUL_B0_W:  begin coef_sel = b0_r; val_sel = w_r;  end
      default:   begin coef_sel = '0;   val_sel = '0;   end
    endcase
  end

  // Shared multiplier, registered
  always_ff @(posedge clk) begin
    prod_r <= coef_sel * val_sel;
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign x_sh     = {{(ACC_W-SAMPLE_W-FRAC_SHIFT){x_r[SAMPLE_W-1]}}, x_r, {FRAC_SHIFT{1'b0}}};

  // Accumulate the inner value and the output sums
  always_ff @(posedge clk) begin
    unique case (cmd.accw_op)
      ACC_INIT: accw_r <= x_sh - prod_ext;
      ACC_STEP: accw_r <= accw_r - prod_ext;
      default:  ;
    endcase
    unique case (cmd.accy_op)
      ACC_INIT: accy_r <= prod_ext;
      ACC_STEP: accy_r <= accy_r + prod_ext;
      default:  ;
    endcase
    if (cmd.w_load) begin
      w_r <= w_sat;
    end
  end

  // Drop the fraction bits and clamp: w to 32 bits, y to 24 bits
  always_comb begin
    if ((&accw_r[ACC_W-1:FRAC_SHIFT+STATE_W-1]) || !(|accw_r[ACC_W-1:FRAC_SHIFT+STATE_W-1])) begin
      w_sat = accw_r[FRAC_SHIFT+STATE_W-1:FRAC_SHIFT];
    end else begin
      w_sat = {accw_r[ACC_W-1], {(STATE_W-1){~accw_r[ACC_W-1]}}};
    end
    if ((&accy_r[ACC_W-1:FRAC_SHIFT+SAMPLE_W-1]) ||
        !(|accy_r[ACC_W-1:FRAC_SHIFT+SAMPLE_W-1])) begin
      y_sat = accy_r[FRAC_SHIFT+SAMPLE_W-1:FRAC_SHIFT];
    end else begin
      y_sat = {accy_r[ACC_W-1], {(SAMPLE_W-1){~accy_r[ACC_W-1]}}};
    end
  end

  // Shift the delay line of the channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        d1_arr_r[i] <= '0;
        d2_arr_r[i] <= '0;
      end
    end else if (cmd.finish && in_range_r) begin
      d1_arr_r[idx_r] <= w_r;
      d2_arr_r[idx_r] <= d1_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      sample_out_r  <= in_range_r ? y_sat : '0;
      channel_out_r <= ch_r;
    end
  end

  assign sample_out  = sample_out_r;
  assign channel_out = channel_out_r;

endmodule

// ===== rtl/core/biquad_df2_filter_multichannel.sv =====
// Top level of the multichannel direct form II biquad filter.
// Instantiates bqdf2_ctrl and bqdf2_dp; depends on bqdf2_pkg.
//
//  channel  direction  payload (low bit up)
//  in_      slave      tdata: sample_in[23:0], channel_index[26:24]
//  out_     master     tdata: sample_out[23:0], channel_out[26:24]
//  cfg_     write      index 0..4 = b0, b1, b2, a1, a2 (Q3.22)
//
// The five products run one after another through a single 26x32 multiplier,
// with a register after it. A new input is accepted only once the previous
// result sits in the output register, so items are processed one at a time.
// Reset (synchronous, active low) loads b0 = 1.0, clears the other
// coefficients and every channel's delay line. An output stall holds the
// finished item in the sequencer until the output register frees.
module biquad_df2_filter_multichannel
  import bqdf2_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // sample_in[23:0], channel_index[26:24]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // sample_out[23:0], channel_out[26:24]
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COEF_W-1:0]     cfg_wdata
);

  bqdf2_cmd_t                 cmd;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic [CH_W-1:0]            channel_out;

  bqdf2_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  bqdf2_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .sample_in     (in_tdata[SAMPLE_W-1:0]),
    .channel_index (in_tdata[SAMPLE_W+CH_W-1:SAMPLE_W]),
    .cmd           (cmd),
    .sample_out    (sample_out),
    .channel_out   (channel_out)
  );

  // Pack the result, zero fill to the byte boundary
  assign out_tdata = {{(OUT_DATA_W-SAMPLE_W-CH_W){1'b0}}, channel_out, sample_out};

endmodule

// ===== rtl/core/bqdf2_checker.sv =====
// Port-level checks for biquad_df2_filter_multichannel, bound to the top level.
// Depends on bqdf2_pkg for port widths.
module bqdf2_checker
  import bqdf2_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // A stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  // The block is still busy at one point in the multiply sequence after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##5 !in_tready)
    else $error("input accepted during multiply sequence");

  // No result can appear soon after an accept into an empty output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared too early");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid set after reset");

endmodule

bind biquad_df2_filter_multichannel bqdf2_checker u_bqdf2_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
